// ===== src/mtm_pkg.sv =====
package mtm_pkg;

  // block sizing
  localparam int MAX_JETS = 128;
  localparam int PT_BITS  = 16;
  localparam int PHI_BITS = 12;

  // azimuth decomposition and sine table
  localparam int K_W     = PHI_BITS - 2;
  localparam int Q_SIZE  = 1 << K_W;
  localparam int ROM_AW  = K_W + 1;
  localparam int SIN_W   = 15;
  localparam int SIN_MAX = (1 << SIN_W) - 1;
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;

  // per-jet parts and event sums
  localparam int SEEN_W  = $clog2(MAX_JETS + 1);
  localparam int PROD_W  = PT_BITS + SIN_W;
  localparam int PART_W  = PT_BITS + 1;
  localparam int SUM_W   = 24;
  localparam int SUM_MAX = (1 << (SUM_W - 1)) - 1;
  localparam int ADD_W   = ((SUM_W > PART_W + 1) ? SUM_W : PART_W + 1) + 1;

  // event queue between accumulator and root unit
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // magnitude and square root
  localparam int MAG_W      = SUM_W - 1;
  localparam int RAD_W      = 2 * SUM_W;
  localparam int ROOT_STEPS = SUM_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int OUT_W      = 23;
  localparam int OUT_MAX    = (1 << OUT_W) - 1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
  } mtm_evt_t;

  typedef logic [Q_SIZE:0][SIN_W-1:0] sin_tab_t;

  // truncating unsigned quotient by shift and subtract, used only to build the table
  function automatic longint unsigned udiv_trunc(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(k*pi/(2*Q_SIZE)) in unsigned q0.15 from a truncating q30 taylor series
  function automatic logic [SIN_W-1:0] quarter_sine(input int k);
    longint unsigned theta;
    longint unsigned term;
    longint          acc;
    longint unsigned r;
    theta = (longint'(k) * HALFPI_Q30) >> K_W;
    term  = theta;
    acc   = longint'(theta);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = udiv_trunc(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0] == 1'b1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (longint'(acc) + 64'd16384) >> 15;
    if (r > longint'(SIN_MAX)) begin
      r = longint'(SIN_MAX);
    end
    return r[SIN_W-1:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int i = 0; i <= Q_SIZE; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

endpackage

// ===== src/mtm_front.sv =====
module mtm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mtm_pkg::PT_BITS-1:0]         in_jet_pt,
  input  logic signed [mtm_pkg::PHI_BITS-1:0] in_jet_phi,
  input  logic                                in_last_jet,
  input  logic [mtm_pkg::Q_CW-1:0]            q_level,
  output logic                                q_push,
  output mtm_pkg::mtm_evt_t                   q_data
);
  import mtm_pkg::*;

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam logic signed [ADD_W-1:0] POS_LIM = ADD_W'(SUM_MAX);
  localparam logic signed [ADD_W-1:0] NEG_LIM = -POS_LIM;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1 << (SIN_W - 1));

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic [PROD_W-1:0]       prod,
    input logic                    neg
  );
    logic [PROD_W:0]         rnd;
    logic [PART_W-1:0]       part;
    logic signed [ADD_W-1:0] p_ext;
    logic signed [ADD_W-1:0] tot;
    rnd   = {1'b0, prod} + RND_HALF;
    part  = rnd[PROD_W:SIN_W];
    p_ext = signed'(ADD_W'(part));
    if (neg) begin
      p_ext = -p_ext;
    end
    tot = ADD_W'(s) + p_ext;
    if (tot > POS_LIM) begin
      tot = POS_LIM;
    end else if (tot < NEG_LIM) begin
      tot = NEG_LIM;
    end
    return tot[SUM_W-1:0];
  endfunction

  logic                       accept;
  logic [K_W-1:0]             in_k;
  logic                       seen_ok;
  logic [Q_CW:0]              pend;
  logic [ROM_AW-1:0]          rom_addr;
  logic [SIN_W-1:0]           rom_q_r;

  // stage 1: first table read issued
  logic                       p1_v_r;
  logic [PT_BITS-1:0]         p1_pt_r;
  logic [1:0]                 p1_quad_r;
  logic [K_W-1:0]             p1_k_r;
  logic                       p1_acc_r;
  logic                       p1_last_r;

  // stage 2: both table values present
  logic                       p2_v_r;
  logic [PT_BITS-1:0]         p2_pt_r;
  logic [1:0]                 p2_quad_r;
  logic                       p2_acc_r;
  logic                       p2_last_r;
  logic [SIN_W-1:0]           a_r;
  logic [SIN_W-1:0]           c_mag;
  logic [SIN_W-1:0]           s_mag;
  logic [PT_BITS-1:0]         pt_eff;

  // stage 3: products ready for accumulation
  logic                       p3_v_r;
  logic [PROD_W-1:0]          p3_cx_r;
  logic [PROD_W-1:0]          p3_sy_r;
  logic                       p3_cneg_r;
  logic                       p3_sneg_r;
  logic                       p3_last_r;

  logic signed [SUM_W-1:0]    sum_x_r;
  logic signed [SUM_W-1:0]    sum_y_r;
  logic signed [SUM_W-1:0]    sum_x_nxt;
  logic signed [SUM_W-1:0]    sum_y_nxt;
  logic                       stopped_r;
  logic [SEEN_W-1:0]          seen_r;

  assign pend = {1'b0, q_level}
              + (Q_CW+1)'(p2_v_r & p2_last_r)
              + (Q_CW+1)'(p3_v_r & p3_last_r);
  assign in_ready = !p1_v_r && (pend < (Q_CW+1)'(Q_DEPTH));
  assign accept   = in_valid && in_ready;
  assign in_k     = in_jet_phi[K_W-1:0];
  assign seen_ok  = seen_r < SEEN_W'(MAX_JETS);

  // one table port, second read for the complementary angle
  assign rom_addr = p1_v_r ? (ROM_AW'(Q_SIZE) - {1'b0, p1_k_r}) : {1'b0, in_k};

  always_ff @(posedge clk) begin
    rom_q_r <= SIN_TAB[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      if (in_last_jet) begin
        seen_r    <= '0;
        stopped_r <= 1'b0;
      end else if (seen_ok) begin
        seen_r <= seen_r + SEEN_W'(1);
        if (in_jet_pt == '0) begin
          stopped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= accept;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_pt_r   <= in_jet_pt;
      p1_quad_r <= in_jet_phi[PHI_BITS-1 -: 2];
      p1_k_r    <= in_k;
      p1_acc_r  <= seen_ok && (in_jet_pt != '0) && !stopped_r;
      p1_last_r <= in_last_jet;
    end
    p2_pt_r   <= p1_pt_r;
    p2_quad_r <= p1_quad_r;
    p2_acc_r  <= p1_acc_r;
    p2_last_r <= p1_last_r;
    a_r       <= rom_q_r;
  end

  // quadrant folding: a is the sine of k, rom_q_r the sine of the complement
  assign c_mag  = p2_quad_r[0] ? a_r : rom_q_r;
  assign s_mag  = p2_quad_r[0] ? rom_q_r : a_r;
  assign pt_eff = p2_acc_r ? p2_pt_r : '0;

  always_ff @(posedge clk) begin
    p3_cx_r   <= PROD_W'(pt_eff) * PROD_W'(c_mag);
    p3_sy_r   <= PROD_W'(pt_eff) * PROD_W'(s_mag);
    p3_cneg_r <= p2_quad_r[1] ^ p2_quad_r[0];
    p3_sneg_r <= p2_quad_r[1];
    p3_last_r <= p2_last_r;
  end

  assign sum_x_nxt = sat_add(sum_x_r, p3_cx_r, p3_cneg_r);
  assign sum_y_nxt = sat_add(sum_y_r, p3_sy_r, p3_sneg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (p3_v_r) begin
      if (p3_last_r) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end else begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
      end
    end
  end

  assign q_push       = p3_v_r && p3_last_r;
  assign q_data.sum_x = sum_x_nxt;
  assign q_data.sum_y = sum_y_nxt;

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_x_r <= signed'(POS_LIM[SUM_W-1:0])) && (sum_x_r >= signed'(NEG_LIM[SUM_W-1:0])) &&
    (sum_y_r <= signed'(POS_LIM[SUM_W-1:0])) && (sum_y_r >= signed'(NEG_LIM[SUM_W-1:0])))
    else $error("event sum outside saturation range");

  a_two_reads: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |=> p2_v_r && !p1_v_r)
    else $error("second table read lost");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_level < Q_CW'(Q_DEPTH))
    else $error("event pushed into full queue");

endmodule

// ===== src/mtm_fifo.sv =====
module mtm_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  mtm_pkg::mtm_evt_t        push_data,
  input  logic                     pop,
  output logic                     pop_valid,
  output mtm_pkg::mtm_evt_t        pop_data,
  output logic [mtm_pkg::Q_CW-1:0] level
);
  import mtm_pkg::*;

  mtm_evt_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(do_pop);
    end
  end

endmodule

// ===== src/mtm_root.sv =====
module mtm_root (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  mtm_pkg::mtm_evt_t         q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mtm_pkg::OUT_W-1:0] out_missing_pt
);
  import mtm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQX  = 3'd1;
  localparam logic [2:0] ST_SQY  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  localparam logic [RAD_W-1:0] BIT_TOP = RAD_W'(1) << (RAD_W - 2);

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic [MAG_W-1:0]        ax_r;
  logic [MAG_W-1:0]        ay_r;
  logic [2*MAG_W-1:0]      xsq_r;
  logic [2*MAG_W-1:0]      ysq_r;
  logic [RAD_W-1:0]        v_r;
  logic [RAD_W-1:0]        res_r;
  logic [RAD_W-1:0]        bit_r;
  logic [RAD_W-1:0]        trial;
  logic [STEP_W-1:0]       step_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_r;
  logic                    out_free;
  logic signed [SUM_W-1:0] nx;
  logic signed [SUM_W-1:0] ny;

  assign trial    = res_r + bit_r;
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign nx       = -q_data.sum_x;
  assign ny       = -q_data.sum_y;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_ROOT;
      ST_ROOT: if (step_r == STEP_W'(ROOT_STEPS - 1)) state_nxt = ST_WAIT;
      ST_WAIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ax_r <= q_data.sum_x[SUM_W-1] ? nx[MAG_W-1:0] : q_data.sum_x[MAG_W-1:0];
        ay_r <= q_data.sum_y[SUM_W-1] ? ny[MAG_W-1:0] : q_data.sum_y[MAG_W-1:0];
      end
      ST_SQX: xsq_r <= (2*MAG_W)'(ax_r) * (2*MAG_W)'(ax_r);
      ST_SQY: ysq_r <= (2*MAG_W)'(ay_r) * (2*MAG_W)'(ay_r);
      ST_ADD: begin
        v_r    <= RAD_W'(xsq_r) + RAD_W'(ysq_r);
        res_r  <= '0;
        bit_r  <= BIT_TOP;
        step_r <= '0;
      end
      ST_ROOT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_WAIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_WAIT) && out_free) begin
      out_r <= (res_r[RAD_W-1:OUT_W] != '0) ? OUT_W'(OUT_MAX) : res_r[OUT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_missing_pt = out_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && (state_r == ST_IDLE))
    else $error("queue popped outside idle");

endmodule

// ===== src/missing_transverse_momentum.sv =====
// a last-jet transaction goes through the front stages, the event queue and the root unit
// a new jet is taken only after both sine table reads of the prior jet are issued
// each event then passes through the shared square root unit, one bit per cycle;
// a 4-entry event queue lets short events outpace the root unit for a while
// reset: synchronous active-low rst_n clears sums, counters, queue and output valid
module missing_transverse_momentum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mtm_pkg::PT_BITS-1:0]         in_jet_pt,
  input  logic signed [mtm_pkg::PHI_BITS-1:0] in_jet_phi,
  input  logic                                in_last_jet,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mtm_pkg::OUT_W-1:0]           out_missing_pt
);
  import mtm_pkg::*;

  // front to queue
  logic             push;
  mtm_evt_t         push_data;
  logic [Q_CW-1:0]  q_level;

  // queue to root unit
  logic             pop;
  logic             pop_valid;
  mtm_evt_t         pop_data;

  // front: takes jet transactions, folds the azimuth into a quadrant and table
  // index, scales pt by cosine and sine, accumulates the saturating x/y sums;
  // on the last jet the finished sums go to the queue and the sums clear
  mtm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_jet_pt   (in_jet_pt),
    .in_jet_phi  (in_jet_phi),
    .in_last_jet (in_last_jet),
    .q_level     (q_level),
    .q_push      (push),
    .q_data      (push_data)
  );

  // short queue of finished events, so the front never waits on the root unit
  // unless several short events pile up
  mtm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .level     (q_level)
  );

  // back: squares both sums, then a bit-per-cycle floor square root; the result
  // sits in an output register so the next event can start while it waits
  mtm_root u_root (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_missing_pt (out_missing_pt)
  );

endmodule

// ===== sim/missing_transverse_momentum_tb.sv =====
`timescale 1ns / 1ps

module missing_transverse_momentum_tb;

  localparam int PT_W  = mtm_pkg::PT_BITS;
  localparam int PHI_W = mtm_pkg::PHI_BITS;
  localparam int MPT_W = mtm_pkg::OUT_W;

  // quarter-turn size of the azimuth code and the q30 value of pi/2
  localparam int QTR_BITS = PHI_W - 2;
  localparam int QTR      = 1 << QTR_BITS;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  localparam int  TRIG_ONE = 32767;
  localparam int  XY_LIMIT = 8388607;
  localparam longint unsigned MPT_LIMIT = 64'd8388607;

  localparam int NUM_JETS_TARGET = 700;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 40;

  // directed table: a row either carries a typed-in missing_pt or is left to the predictor
  typedef struct packed {
    logic [PT_W-1:0]  pt;
    logic [PHI_W-1:0] phi;
    logic             last;
    logic             fixed;
    logic [MPT_W-1:0] mpt;
  } jet_row_t;

  localparam int NUM_ROWS = 21;
  localparam jet_row_t JET_ROWS [NUM_ROWS] = '{
    // empty event: one zero-momentum jet marked last
    '{16'h0000, 12'h000, 1'b1, 1'b1, 23'd0},
    // single jets at the momentum and azimuth extremes
    '{16'hFFFF, 12'h000, 1'b1, 1'b0, 23'd0},
    '{16'hFFFF, 12'h800, 1'b1, 1'b0, 23'd0},
    '{16'h0001, 12'h7FF, 1'b1, 1'b0, 23'd0},
    // back-to-back jets along y, cancelling exactly
    '{16'hFFFF, 12'h400, 1'b0, 1'b0, 23'd0},
    '{16'hFFFF, 12'hC00, 1'b1, 1'b0, 23'd0},
    // zero momentum first, so the later jet adds nothing
    '{16'h0000, 12'h200, 1'b0, 1'b0, 23'd0},
    '{16'h9C40, 12'h064, 1'b1, 1'b1, 23'd0},
    // zero momentum mid-event, only the first jet counts
    '{16'h7530, 12'h100, 1'b0, 1'b0, 23'd0},
    '{16'h0000, 12'h000, 1'b0, 1'b0, 23'd0},
    '{16'hFFFF, 12'h000, 1'b1, 1'b0, 23'd0},
    // alternating bit patterns on both fields
    '{16'hAAAA, 12'h555, 1'b0, 1'b0, 23'd0},
    '{16'h5555, 12'hAAA, 1'b1, 1'b0, 23'd0},
    // one jet on each diagonal, one per quadrant
    '{16'hFFFF, 12'h200, 1'b0, 1'b0, 23'd0},
    '{16'hFFFF, 12'h600, 1'b0, 1'b0, 23'd0},
    '{16'hFFFF, 12'hA00, 1'b0, 1'b0, 23'd0},
    '{16'hFFFF, 12'hE00, 1'b1, 1'b0, 23'd0},
    // either side of the quadrant boundary
    '{16'h8000, 12'h3FF, 1'b0, 1'b0, 23'd0},
    '{16'h7FFF, 12'h401, 1'b1, 1'b0, 23'd0},
    // empty event again, top azimuth code
    '{16'h0000, 12'h7FF, 1'b1, 1'b1, 23'd0},
    '{16'h0001, 12'h000, 1'b1, 1'b0, 23'd0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PT_W-1:0]         in_jet_pt = '0;
  logic signed [PHI_W-1:0] in_jet_phi = '0;
  logic                    in_last_jet = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [MPT_W-1:0]        out_missing_pt;

  missing_transverse_momentum dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_jet_pt      (in_jet_pt),
    .in_jet_phi     (in_jet_phi),
    .in_last_jet    (in_last_jet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_missing_pt (out_missing_pt)
  );

  always #10 clk = ~clk;

  // predictor state: running x/y sums of the current event
  int               sine_q15 [QTR+1];
  int               px_sum;
  int               py_sum;
  bit               evt_halted;
  int               evt_jets;
  logic [MPT_W-1:0] mpt_expected [$];

  int err_count = 0;
  int jets_sent;
  int burst_left;
  int idle_cycles = 0;
  int rdy_tick = 0;
  int rdy_mode = 0;

  // sine of idx quarter-steps, q30 taylor series with truncation, rounded to q1.15
  function automatic int taylor_sine_q15(input int idx);
    longint unsigned ang;
    longint unsigned term;
    longint unsigned dv;
    longint unsigned rnd;
    longint          accum;
    ang   = longint'(idx);
    ang   = (ang * PI_HALF_Q30) >> QTR_BITS;
    term  = ang;
    accum = longint'(ang);
    for (int n = 1; n <= 12; n++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      dv   = longint'((2 * n) * (2 * n + 1));
      term = term / dv;
      if (n % 2 == 1) begin
        accum = accum - longint'(term);
      end else begin
        accum = accum + longint'(term);
      end
    end
    if (accum < 0) begin
      accum = 0;
    end
    rnd = (longint'(accum) + 64'd16384) >> 15;
    if (rnd > longint'(TRIG_ONE)) begin
      rnd = longint'(TRIG_ONE);
    end
    return int'(rnd);
  endfunction

  // momentum times q1.15 factor, rounded half up on the magnitude
  function automatic int resolve_part(input int pt, input int trig);
    longint mag;
    longint prod;
    mag  = longint'((trig < 0) ? -trig : trig);
    prod = (longint'(pt) * mag + 16384) >>> 15;
    return int'((trig < 0) ? -prod : prod);
  endfunction

  function automatic int clamp_sum(input int acc, input int part);
    longint s;
    s = longint'(acc) + longint'(part);
    if (s > XY_LIMIT) begin
      s = XY_LIMIT;
    end
    if (s < -XY_LIMIT) begin
      s = -XY_LIMIT;
    end
    return int'(s);
  endfunction

  // bitwise floor square root, the magnitude squared stays below 2^48
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned cand;
    res = 0;
    for (int b = 23; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) begin
        res = cand;
      end
    end
    return res;
  endfunction

  // fold one jet into the event sums, giving missing_pt when the jet closes the event
  task automatic absorb_jet(input logic [PT_W-1:0] pt, input logic [PHI_W-1:0] phi,
                            input logic last, output bit emits, output logic [MPT_W-1:0] mpt);
    int               k;
    int               sn;
    int               cs;
    int               lo;
    int               hi;
    longint           xx;
    longint           yy;
    longint unsigned  mag;
    emits = 1'b0;
    mpt   = '0;
    if (evt_jets < mtm_pkg::MAX_JETS) begin
      evt_jets++;
      if (pt == '0) begin
        evt_halted = 1'b1;
      end
      if (!evt_halted) begin
        k  = int'(phi[QTR_BITS-1:0]);
        lo = sine_q15[k];
        hi = sine_q15[QTR-k];
        case (phi[PHI_W-1:PHI_W-2])
          2'd0: begin sn = lo;  cs = hi;  end
          2'd1: begin sn = hi;  cs = -lo; end
          2'd2: begin sn = -lo; cs = -hi; end
          default: begin sn = -hi; cs = lo; end
        endcase
        px_sum = clamp_sum(px_sum, resolve_part(int'(pt), cs));
        py_sum = clamp_sum(py_sum, resolve_part(int'(pt), sn));
      end
    end
    if (last) begin
      xx  = longint'(px_sum);
      yy  = longint'(py_sum);
      mag = floor_root(longint'(xx * xx + yy * yy));
      if (mag > MPT_LIMIT) begin
        mag = MPT_LIMIT;
      end
      emits      = 1'b1;
      mpt        = mag[MPT_W-1:0];
      px_sum     = 0;
      py_sum     = 0;
      evt_halted = 1'b0;
      evt_jets   = 0;
    end
  endtask

  // present one jet, hold it until the transaction completes, then maybe pause the sender
  task automatic send_jet(input logic [PT_W-1:0] pt, input logic [PHI_W-1:0] phi,
                          input logic last, input bit fixed, input logic [MPT_W-1:0] typed);
    bit               emits;
    logic [MPT_W-1:0] mpt;
    int               gap;
    in_valid    <= 1'b1;
    in_jet_pt   <= pt;
    in_jet_phi  <= phi;
    in_last_jet <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    jets_sent++;
    absorb_jet(pt, phi, last, emits, mpt);
    if (emits) begin
      mpt_expected.insert(mpt_expected.size(), fixed ? typed : mpt);
    end
    burst_left--;
    if (burst_left <= 0) begin
      // next burst: mostly short, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: out_ready follows one of four stall patterns, redrawn at random
  always @(posedge clk) begin
    rdy_tick++;
    if (rdy_tick % 150 == 0) begin
      rdy_mode = $urandom_range(0, 3);
    end
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rdy_tick % 7) < 3;
      default: out_ready <= (rdy_tick % 16) == 0;
    endcase
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mpt_expected.size() == 0) begin
        $error("missing_pt: unexpected result %0d with nothing outstanding", out_missing_pt);
        err_count++;
      end else if (out_missing_pt !== mpt_expected[0]) begin
        $error("missing_pt: expected %0d, actual %0d", mpt_expected[0], out_missing_pt);
        err_count++;
        void'(mpt_expected.pop_front());
      end else begin
        void'(mpt_expected.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          len;
    int          roll;
    logic [15:0] pt;
    jets_sent   = 0;
    burst_left  = 1;
    px_sum      = 0;
    py_sum      = 0;
    evt_halted  = 1'b0;
    evt_jets    = 0;
    for (int i = 0; i <= QTR; i++) begin
      sine_q15[i] = taylor_sine_q15(i);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_jet(JET_ROWS[i].pt, JET_ROWS[i].phi, JET_ROWS[i].last,
               JET_ROWS[i].fixed, JET_ROWS[i].mpt);
    end

    // over-full event: jets past the cap must be ignored, the last one still closes it
    for (int j = 0; j < mtm_pkg::MAX_JETS + 3; j++) begin
      send_jet(16'hFFFF, 12'h000, j == mtm_pkg::MAX_JETS + 2, 1'b0, '0);
    end

    // random events, mostly short, a few running past the cap
    while (jets_sent < NUM_JETS_TARGET) begin
      roll = $urandom_range(0, 99);
      len  = (roll < 3) ? $urandom_range(120, 140) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          pt = '0;
        end else if (roll < 16) begin
          pt = 16'hFFFF;
        end else if (roll < 24) begin
          pt = 16'($urandom_range(1, 15));
        end else begin
          pt = 16'($urandom_range(1, 65535));
        end
        send_jet(pt, PHI_W'($urandom), j == len - 1, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then give a stray result time to show up
    while (mpt_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
